### sv/tqle_pkg.sv
package tqle_pkg;

  // table geometry
  localparam int STATE_COUNT  = 128;
  localparam int ACTION_COUNT = 2;
  localparam int ROW_W        = $clog2(STATE_COUNT);
  localparam int ACT_W        = $clog2(ACTION_COUNT);
  localparam int ADDR_W       = ROW_W + ACT_W;
  localparam int DEPTH        = STATE_COUNT * ACTION_COUNT;

  // number formats
  localparam int QV_W   = 20;                      // q value, 12 fraction bits
  localparam int FRAC_W = 16;                      // unsigned 0.16 fractions
  localparam int WORK_W = 24;                      // target, difference, sums
  localparam int PROD_W = WORK_W + FRAC_W + 1;     // shared multiplier output

  localparam logic signed [WORK_W-1:0] QV_MAX = WORK_W'(524287);
  localparam logic signed [WORK_W-1:0] QV_MIN = -WORK_W'(524288);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

  localparam logic [FRAC_W-1:0] RST_LEARNING_RATE     = 16'd9830;
  localparam logic [FRAC_W-1:0] RST_DISCOUNT          = 16'd64881;
  localparam logic [FRAC_W-1:0] RST_EXPLORE_THRESHOLD = 16'd6554;

  // commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

endpackage

### sv/tqle_ram.sv
module tqle_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tabular_q_learning_engine.sv
// Tabular Q-learning engine with epsilon-greedy action selection. The value table holds
// STATE_COUNT x ACTION_COUNT entries of signed 20-bit fixed point (12 fraction bits) in a
// single-port-read RAM, and every entry reads as zero after reset through a bank of per-entry
// valid bits, so no clearing pass is needed. One transaction is processed at a time: an
// update scans the next state's row for its maximum, scales it by the discount (skipped when
// terminal), reads the current entry and writes back entry + rate*(target - entry); a greedy
// select scans its row and an exploring select reads the random action's entry. The one RAM
// read port reads one table entry per cycle, and the single shared 24x17 multiplier forms
// first discount*max and then rate*(target-q). A finished result sits in an output register,
// so the next transaction is accepted while it waits. Configuration is a plain write port:
// index 0 learning rate, 1 discount, 2 explore threshold, all unsigned 0.16 fractions.
module tabular_q_learning_engine
  import tqle_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [FRAC_W-1:0]        cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [ROW_W-1:0]         state_index_i,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [QV_W-1:0]   reward_i,
  input  logic [ROW_W-1:0]         next_state_index_i,
  input  logic                     terminal_i,
  input  logic [FRAC_W-1:0]        random_draw_i,
  input  logic [ACT_W-1:0]         random_action_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ACT_W-1:0]         chosen_action_o,
  output logic signed [QV_W-1:0]   q_value_o,
  output logic                     explored_o
);

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN      = 9'b000000010,  // issue one read per action of the row
    S_SCAN_LAST = 9'b000000100,  // last read of the row lands
    S_MULG      = 9'b000001000,  // discount * row maximum
    S_RCUR      = 9'b000010000,  // form target, read current entry
    S_DIFF      = 9'b000100000,  // target - current
    S_MULA      = 9'b001000000,  // rate * difference
    S_NEW       = 9'b010000000,  // new entry, write back
    S_OUT       = 9'b100000000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [FRAC_W-1:0] rate_q, discount_q, explore_q;

  // latched transaction
  logic                     cmd_q;
  logic [ROW_W-1:0]         s_q;
  logic [ROW_W-1:0]         row_q;     // row scanned for the maximum
  logic [ACT_W-1:0]         a_q;       // column read or written
  logic signed [QV_W-1:0]   reward_q;
  logic                     term_q;
  logic                     expl_q;

  // datapath registers
  logic [ACT_W-1:0]           act_cnt_q;
  logic                       cmp_vld_q;
  logic [ACT_W-1:0]           cmp_act_q;
  logic signed [QV_W-1:0]     best_q;
  logic [ACT_W-1:0]           pick_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [WORK_W-1:0]   target_q;
  logic signed [WORK_W-1:0]   diff_q;
  logic signed [WORK_W-1:0]   cur_q;

  // table storage and per-entry valid bits
  logic [DEPTH-1:0]  valid_q;
  logic              rd_vld_q;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [QV_W-1:0]   ram_wdata, ram_rdata;
  logic signed [QV_W-1:0] rdata_eff;

  // output register
  logic                   out_valid_q;
  logic [ACT_W-1:0]       out_action_q;
  logic signed [QV_W-1:0] out_qv_q;
  logic                   out_expl_q;

  // shared multiplier and its rounding
  logic signed [WORK_W-1:0] mul_a;
  logic [FRAC_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [WORK_W-1:0] rnd;

  logic                     accept;
  logic                     explore_now;
  logic                     out_load;
  logic signed [WORK_W-1:0] nv_wide;
  logic signed [QV_W-1:0]   nv_sat;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign explore_now = (command_i == CMD_SELECT) && (random_draw_i < explore_q);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // an entry never written since reset reads as zero
  assign rdata_eff = rd_vld_q ? $signed(ram_rdata) : '0;

  // multiplier operand select: discount*max first, rate*difference later
  always_comb begin
    if (state_q == S_MULA) begin
      mul_a = diff_q;
      mul_b = rate_q;
    end else begin
      mul_a = WORK_W'(best_q);
      mul_b = discount_q;
    end
  end

  assign prod_d = mul_a * $signed({1'b0, mul_b});

  // round to nearest, halves toward plus infinity
  assign rnd_full = (prod_q + ROUND_HALF) >>> FRAC_W;
  assign rnd      = rnd_full[WORK_W-1:0];

  // new entry with saturation to the q range
  assign nv_wide = cur_q + rnd;
  always_comb begin
    if (nv_wide > QV_MAX) begin
      nv_sat = QV_MAX[QV_W-1:0];
    end else if (nv_wide < QV_MIN) begin
      nv_sat = QV_MIN[QV_W-1:0];
    end else begin
      nv_sat = nv_wide[QV_W-1:0];
    end
  end

  // table port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {s_q, a_q};
    case (state_q)
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = {row_q, act_cnt_q};
      end
      S_RCUR: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign ram_we    = (state_q == S_NEW);
  assign ram_waddr = {s_q, a_q};
  assign ram_wdata = nv_sat;

  tqle_ram #(
    .WIDTH(QV_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (explore_now || (command_i == CMD_UPDATE && terminal_i)) begin
            state_d = S_RCUR;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (act_cnt_q == ACT_W'(ACTION_COUNT - 1)) begin
          state_d = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_d = (cmd_q == CMD_UPDATE) ? S_MULG : S_OUT;
      end
      S_MULG: state_d = S_RCUR;
      S_RCUR: state_d = S_DIFF;
      S_DIFF: begin
        state_d = (cmd_q == CMD_SELECT) ? S_OUT : S_MULA;
      end
      S_MULA: state_d = S_NEW;
      S_NEW:  state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= RST_LEARNING_RATE;
      discount_q  <= RST_DISCOUNT;
      explore_q   <= RST_EXPLORE_THRESHOLD;
      valid_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_SCAN);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEARNING_RATE:     rate_q     <= cfg_data_i;
          CFG_DISCOUNT:          discount_q <= cfg_data_i;
          CFG_EXPLORE_THRESHOLD: explore_q  <= cfg_data_i;
          default: ;  // index beyond the list is ignored
        endcase
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= command_i;
      s_q       <= state_index_i;
      row_q     <= (command_i == CMD_UPDATE) ? next_state_index_i : state_index_i;
      a_q       <= (command_i == CMD_SELECT) ? random_action_i : action_i;
      reward_q  <= reward_i;
      term_q    <= terminal_i;
      expl_q    <= explore_now;
      act_cnt_q <= '0;
    end
    if (state_q == S_SCAN) begin
      cmp_act_q <= act_cnt_q;
      act_cnt_q <= act_cnt_q + ACT_W'(1);
    end
    if (ram_re) begin
      rd_vld_q <= valid_q[ram_raddr];
    end

    // running maximum, ties keep the lower action
    if (cmp_vld_q) begin
      if (cmp_act_q == '0 || rdata_eff > best_q) begin
        best_q <= rdata_eff;
        pick_q <= cmp_act_q;
      end
    end

    if (state_q == S_MULG || state_q == S_MULA) begin
      prod_q <= prod_d;
    end
    if (state_q == S_RCUR) begin
      target_q <= term_q ? WORK_W'(reward_q) : WORK_W'(reward_q) + rnd;
    end
    if (state_q == S_DIFF) begin
      cur_q  <= WORK_W'(rdata_eff);
      diff_q <= target_q - WORK_W'(rdata_eff);
      if (cmd_q == CMD_SELECT) begin
        // exploring select returns the random action's entry
        best_q <= rdata_eff;
        pick_q <= a_q;
      end
    end
    if (state_q == S_NEW) begin
      best_q <= nv_sat;
      pick_q <= a_q;
    end

    if (out_load) begin
      out_action_q <= pick_q;
      out_qv_q     <= best_q;
      out_expl_q   <= expl_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = out_action_q;
  assign q_value_o       = out_qv_q;
  assign explored_o      = out_expl_q;

  // a select transaction never writes the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cmd_q == CMD_UPDATE))
    else $error("table write during select transaction");

  // row comparisons only follow scan reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_SCAN || state_q == S_SCAN_LAST))
    else $error("row compare outside a scan");

  // a written entry is marked valid on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(ram_waddr)])
    else $error("written entry not marked valid");

  // the exploration flag belongs to select transactions only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && expl_q) |-> (cmd_q == CMD_SELECT))
    else $error("exploration flag set on update");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tqle_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 16;      // extra wait after the last result is back
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int SHOWN_ERRORS = 10;

  // index past the end of the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // one input transaction
  typedef struct packed {
    logic                   command;
    logic [ROW_W-1:0]       state_index;
    logic [ACT_W-1:0]       action;
    logic signed [QV_W-1:0] reward;
    logic [ROW_W-1:0]       next_state_index;
    logic                   terminal;
    logic [FRAC_W-1:0]      random_draw;
    logic [ACT_W-1:0]       random_action;
  } txn_t;

  // one result transaction
  typedef struct packed {
    logic [ACT_W-1:0]       chosen_action;
    logic signed [QV_W-1:0] q_value;
    logic                   explored;
  } outcome_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [FRAC_W-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   command_i;
  logic [ROW_W-1:0]       state_index_i;
  logic [ACT_W-1:0]       action_i;
  logic signed [QV_W-1:0] reward_i;
  logic [ROW_W-1:0]       next_state_index_i;
  logic                   terminal_i;
  logic [FRAC_W-1:0]      random_draw_i;
  logic [ACT_W-1:0]       random_action_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [ACT_W-1:0]       chosen_action_o;
  logic signed [QV_W-1:0] q_value_o;
  logic                   explored_o;

  tabular_q_learning_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .state_index_i      (state_index_i),
    .action_i           (action_i),
    .reward_i           (reward_i),
    .next_state_index_i (next_state_index_i),
    .terminal_i         (terminal_i),
    .random_draw_i      (random_draw_i),
    .random_action_i    (random_action_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .chosen_action_o    (chosen_action_o),
    .q_value_o          (q_value_o),
    .explored_o         (explored_o)
  );

  // shadow copy of the value table and of the registers
  logic signed [QV_W-1:0] q_shadow [DEPTH];
  logic [FRAC_W-1:0]      alpha_shadow;
  logic [FRAC_W-1:0]      gamma_shadow;
  logic [FRAC_W-1:0]      epsilon_shadow;

  // results predicted at acceptance, oldest first
  outcome_t pending_outcomes [$];

  int  error_count;
  int  cycle_count;
  // when set, neither side inserts gaps or stalls
  bit  no_idle;

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // fraction times q value, rounded to nearest with halves going up
  function automatic longint frac_scale(longint q, logic [FRAC_W-1:0] f);
    longint p;
    p = q * longint'(f);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint table_entry(logic [ROW_W-1:0] s, logic [ACT_W-1:0] a);
    return longint'(q_shadow[int'(s) * ACTION_COUNT + int'(a)]);
  endfunction

  // argmax of a row, the lowest action wins on ties
  function automatic void row_maximum(input logic [ROW_W-1:0] s,
                                      output logic [ACT_W-1:0] pick,
                                      output longint best);
    pick = '0;
    best = table_entry(s, '0);
    for (int a = 1; a < ACTION_COUNT; a++) begin
      if (table_entry(s, ACT_W'(a)) > best) begin
        best = table_entry(s, ACT_W'(a));
        pick = ACT_W'(a);
      end
    end
  endfunction

  // applies one command to the shadow table and returns the result it yields
  function automatic outcome_t q_learning_step(txn_t t);
    outcome_t         o;
    logic [ACT_W-1:0] pick;
    longint           best;
    longint           future;
    longint           target;
    longint           current;
    longint           updated;
    if (t.command == CMD_UPDATE) begin
      future = 0;
      if (!t.terminal) begin
        row_maximum(t.next_state_index, pick, best);
        future = frac_scale(best, gamma_shadow);
      end
      // target and difference stay at full width, only the entry saturates
      target  = longint'($signed(t.reward)) + future;
      current = table_entry(t.state_index, t.action);
      updated = current + frac_scale(target - current, alpha_shadow);
      if (updated > 64'sd524287)  updated = 64'sd524287;
      if (updated < -64'sd524288) updated = -64'sd524288;
      q_shadow[int'(t.state_index) * ACTION_COUNT + int'(t.action)] = QV_W'(updated);
      o.chosen_action = t.action;
      o.q_value       = QV_W'(updated);
      o.explored      = 1'b0;
    end else if (t.random_draw < epsilon_shadow) begin
      // exploring: take the supplied action
      o.chosen_action = t.random_action;
      o.q_value       = QV_W'(table_entry(t.state_index, t.random_action));
      o.explored      = 1'b1;
    end else begin
      row_maximum(t.state_index, pick, best);
      o.chosen_action = pick;
      o.q_value       = QV_W'(best);
      o.explored      = 1'b0;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // every accepted result is held against the oldest prediction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        log_error($sformatf("result with nothing pending: action %0d q %0d explored %0b",
                            chosen_action_o, q_value_o, explored_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (chosen_action_o !== want.chosen_action || q_value_o !== want.q_value ||
            explored_o !== want.explored) begin
          log_error($sformatf({"result mismatch: action exp %0d got %0d, q exp %0d got %0d, ",
                               "explored exp %0b got %0b"},
                              want.chosen_action, chosen_action_o, want.q_value, q_value_o,
                              want.explored, explored_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_length();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: runs of ready broken by stalls of random length
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 40);
      repeat (n) @(negedge clk_i) out_ready_i <= 1'b1;
      n = idle_length();
      if (n == 0 && !no_idle) n = 1;
      if (!no_idle) repeat (n) @(negedge clk_i) out_ready_i <= 1'b0;
    end
  end

  // presents one transaction after a gap and predicts its result on acceptance;
  // valid is left high so that a following transaction can go back to back
  task automatic send_txn(txn_t t);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    command_i          <= t.command;
    state_index_i      <= t.state_index;
    action_i           <= t.action;
    reward_i           <= t.reward;
    next_state_index_i <= t.next_state_index;
    terminal_i         <= t.terminal;
    random_draw_i      <= t.random_draw;
    random_action_i    <= t.random_action;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(q_learning_step(t));
  endtask

  // stop sending and wait until every predicted result is back
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE:     alpha_shadow   = value;
      CFG_DISCOUNT:          gamma_shadow   = value;
      CFG_EXPLORE_THRESHOLD: epsilon_shadow = value;
      default: ;
    endcase
  endtask

  // registers change only with the engine idle
  task automatic configure(logic [FRAC_W-1:0] alpha, logic [FRAC_W-1:0] gamma,
                           logic [FRAC_W-1:0] epsilon);
    drain();
    write_register(CFG_LEARNING_RATE, alpha);
    write_register(CFG_DISCOUNT, gamma);
    write_register(CFG_EXPLORE_THRESHOLD, epsilon);
  endtask

  // fields unused by a command carry random bits
  function automatic txn_t update_txn(int s, int a, int r, int ns, bit term);
    txn_t t;
    t                  = txn_t'({$urandom, $urandom});
    t.command          = CMD_UPDATE;
    t.state_index      = ROW_W'(s);
    t.action           = ACT_W'(a);
    t.reward           = QV_W'(r);
    t.next_state_index = ROW_W'(ns);
    t.terminal         = term;
    return t;
  endfunction

  function automatic txn_t select_txn(int s, int draw, int ra);
    txn_t t;
    t               = txn_t'({$urandom, $urandom});
    t.command       = CMD_SELECT;
    t.state_index   = ROW_W'(s);
    t.random_draw   = FRAC_W'(draw);
    t.random_action = ACT_W'(ra);
    return t;
  endfunction

  // rows bunched on a few states so values build up and feed each other
  function automatic int pick_row();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 7);
    return $urandom_range(0, STATE_COUNT - 1);
  endfunction

  function automatic txn_t random_txn();
    txn_t t;
    int   r;
    t                  = txn_t'({$urandom, $urandom});
    t.state_index      = ROW_W'(pick_row());
    t.next_state_index = ROW_W'(pick_row());
    t.terminal         = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (r < 4)       t.reward = QV_W'(int'($urandom_range(0, 16383)) - 8192);
    else if (r == 8) t.reward = QV_W'(524287);
    else if (r == 9) t.reward = QV_W'(-524288);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cleared table and reset register values
  task automatic test_reset_defaults();
    send_txn(select_txn(0, 6554, 1));                  // on epsilon: greedy, tie gives 0
    send_txn(select_txn(0, 6553, 1));                  // just below epsilon: explore
    send_txn(update_txn(3, 1, 4096, 4, 1'b0));
    send_txn(select_txn(3, 65535, 0));                 // positive entry wins the row
  endtask

  // full rate and discount push entries into both saturation limits
  task automatic test_saturation();
    configure(16'hFFFF, 16'hFFFF, 16'h0000);
    send_txn(update_txn(127, 1, 524287, 127, 1'b1));
    send_txn(update_txn(127, 1, 524287, 127, 1'b0));
    send_txn(update_txn(127, 0, 524287, 127, 1'b0));
    send_txn(update_txn(0, 1, -524288, 0, 1'b1));
    send_txn(update_txn(0, 0, -524288, 0, 1'b0));
    send_txn(update_txn(0, 1, -524288, 0, 1'b0));     // negative future, hits the floor
    send_txn(select_txn(127, 0, 1));                   // zero epsilon never explores, tie
    send_txn(select_txn(0, 0, 0));                     // both negative, higher is action 0
  endtask

  // zero rate leaves entries alone, top epsilon explores on all but the top draw
  task automatic test_register_extremes();
    configure(16'h0000, 16'h0000, 16'hFFFF);
    send_txn(update_txn(127, 0, 0, 127, 1'b0));
    send_txn(select_txn(127, 65535, 1));
    send_txn(select_txn(127, 65534, 1));
    drain();
    // index beyond the register list must change nothing
    write_register(CFG_UNUSED, 16'h0000);
    send_txn(select_txn(127, 65534, 0));
    configure(16'hFFFF, 16'h0000, RST_EXPLORE_THRESHOLD);
    send_txn(update_txn(10, 1, -4096, 127, 1'b0));     // zero discount drops the future
    send_txn(update_txn(10, 0, -4096, 127, 1'b0));
    send_txn(select_txn(10, 65535, 1));                // equal negative entries, tie
  endtask

  // long random traffic over several register settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       configure(RST_LEARNING_RATE, RST_DISCOUNT, RST_EXPLORE_THRESHOLD);
        1:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       configure(16'h0000, 16'h0000, 16'h0000);
        default: configure(FRAC_W'($urandom), FRAC_W'($urandom), FRAC_W'($urandom));
      endcase
      // one phase runs with no idling on either side
      no_idle = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_txn(random_txn());
      end
      // sender holds off until every result is back
      drain();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    error_count        = 0;
    cycle_count        = 0;
    no_idle            = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    command_i          = CMD_UPDATE;
    state_index_i      = '0;
    action_i           = '0;
    reward_i           = '0;
    next_state_index_i = '0;
    terminal_i         = 1'b0;
    random_draw_i      = '0;
    random_action_i    = '0;
    foreach (q_shadow[i]) q_shadow[i] = '0;
    alpha_shadow   = RST_LEARNING_RATE;
    gamma_shadow   = RST_DISCOUNT;
    epsilon_shadow = RST_EXPLORE_THRESHOLD;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_saturation();
    test_register_extremes();
    test_random_traffic();
    drain();

    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### tabular_q_learning_engine.f
sv/tqle_pkg.sv
sv/tqle_ram.sv
sv/tabular_q_learning_engine.sv
tb/testbench.sv
